/* rtl/ffa_pkg.sv */
// shared types and constants of the first-fit heap allocator
// no dependencies; used by ffa_ctrl, ffa_dp and first_fit_heap_allocator
`default_nettype none

package ffa_pkg;

  localparam int REQ_W  = 13;
  localparam int ADDR_W = 32;
  localparam int LF_W   = 13;
  localparam int DATA_W = 32;

  localparam logic [LF_W-1:0] LF_MAX = 13'h1FFF;

  // operation and status codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_FAIL  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic              status;
    logic [LF_W-1:0]   largest_free;
  } out_t;

  // datapath commands issued by the controller
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_LOAD,
    CMD_ARD,
    CMD_ACHK,
    CMD_AWC,
    CMD_AWD,
    CMD_PRD,
    CMD_PWR,
    CMD_FRD,
    CMD_FCHK,
    CMD_FNX,
    CMD_FPV,
    CMD_FPC,
    CMD_FZC,
    CMD_FWC,
    CMD_SRD,
    CMD_SCHK,
    CMD_OUT
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic fit;
    logic a_end;
    logic split;
    logic foff_ok;
    logic q_start;
    logic q_free;
    logic nx_ok;
    logic pv_ok;
    logic merged;
    logic fol_ok;
    logic s_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
// top level of the first-fit heap allocator: config port, controller, datapath
// depends on ffa_pkg, ffa_ctrl and ffa_dp
`default_nettype none

// First-fit heap allocator with coalescing. After reset the block runs a
// clearing pass over all HEAP_BYTES entries of the header memory, during which
// no beat is accepted. An allocate walks the chunk chain until a fit or the
// end of the chain, then writes the used chunk and, on a split, the split-off
// chunk; a free merges the freed chunk with free neighbours. Every operation
// then rescans the whole chain to find the largest free payload, one chunk at
// a time through the single-port header memory. One item is in work at a time;
// the result register lets the next beat enter while a result waits.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire ffa_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output ffa_pkg::out_t                   out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [ffa_pkg::DATA_W-1:0] pwdata,
  output logic [ffa_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  logic [ffa_pkg::ADDR_W-1:0] base_r;
  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      base_r <= pwdata;
    end
  end

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ffa_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .base      (base_r),
    .in_data   (in_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a failed allocate grants no address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ffa_pkg::ST_FAIL) |-> (out_data.result_addr == '0))
    else $error("failed allocate with address");

  // reset always leads into the clearing pass
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("beat accepted right after reset");

  // a taken beat is never directly followed by a new result
  a_no_same: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result raised right after accept");

endmodule

`default_nettype wire

/* rtl/ffa_dp.sv */
// datapath of the heap allocator: header memory, walk registers, result register
// depends on ffa_pkg; driven by commands from ffa_ctrl
`default_nettype none

module ffa_dp #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ffa_pkg::cmd_t              cmd,
  input  wire logic [ffa_pkg::ADDR_W-1:0] base,
  input  wire ffa_pkg::in_t               in_data,
  input  wire logic                       out_stall,
  output ffa_pkg::sts_t                   sts,
  output logic                            out_valid,
  output ffa_pkg::out_t                   out_data
);

  localparam int OW = $clog2(HEAP_BYTES);
  localparam int AW = ((OW > 14) ? OW : 14) + 2;
  localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] HDR_A  = AW'(HEADER_BYTES);
  localparam logic [OW-1:0] INIT_SZ  = OW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [OW-1:0] LAST_IDX = OW'(HEAP_BYTES - 1);

  typedef struct packed {
    logic          start;
    logic          used;
    logic [OW-1:0] size;
    logic [OW-1:0] prev;
    logic [OW-1:0] next;
  } hdr_t;

  hdr_t mem [HEAP_BYTES];
  hdr_t mem_q;

  ffa_pkg::in_t  in_r;
  ffa_pkg::out_t out_r;
  hdr_t          cur_r, cur_nxt;
  logic [OW-1:0] off_r, soff_r, best_r, prv_base_r, prv_nx_r, clr_cnt_r;
  logic          fail_r, merged_r, out_valid_r;

  logic [AW-1:0] sz_a, step_a, a_sum, s_sum, fol_sum;
  logic [ffa_pkg::ADDR_W-1:0] foff;
  logic [OW-1:0] noff, poff, ra, wa, pm_next, lf_sat;
  logic          q_free, we, out_free;
  hdr_t          wd, dn, pm;

  // request rounding and walk arithmetic
  assign sz_a    = (AW'(in_r.req_size) + AW'(3)) & ~AW'(3);
  assign step_a  = HDR_A + sz_a;
  assign a_sum   = AW'(off_r) + AW'(mem_q.next);
  assign s_sum   = AW'(soff_r) + AW'(mem_q.next);
  assign fol_sum = AW'(prv_base_r) + AW'(prv_nx_r);
  assign foff    = in_r.free_addr - base - ffa_pkg::ADDR_W'(HEADER_BYTES);
  assign noff    = off_r + cur_r.next;
  assign poff    = off_r - cur_r.prev;
  assign q_free  = mem_q.start && !mem_q.used;
  assign out_free = !out_valid_r || !out_stall;

  // status to the controller
  always_comb begin
    sts.clr_last = (clr_cnt_r == LAST_IDX);
    sts.op_free  = (in_r.op == ffa_pkg::OP_FREE);
    sts.fit      = q_free && (AW'(mem_q.size) >= sz_a);
    sts.a_end    = (mem_q.next == '0) || (a_sum >= HEAP_A);
    sts.split    = (AW'(cur_r.size) > step_a) && ((AW'(off_r) + step_a) < HEAP_A);
    sts.foff_ok  = (foff < ffa_pkg::ADDR_W'(HEAP_BYTES));
    sts.q_start  = mem_q.start;
    sts.q_free   = q_free;
    sts.nx_ok    = (mem_q.next != '0) && (a_sum < HEAP_A);
    sts.pv_ok    = (cur_r.prev != '0) && (cur_r.prev <= off_r);
    sts.merged   = merged_r;
    sts.fol_ok   = (prv_nx_r != '0) && (fol_sum < HEAP_A);
    sts.s_end    = (mem_q.next == '0) || (s_sum >= HEAP_A);
    sts.out_free = out_free;
  end

  // split-off chunk and merged previous chunk
  always_comb begin
    dn.start = 1'b1;
    dn.used  = 1'b0;
    dn.size  = OW'(AW'(cur_r.size) - step_a);
    dn.prev  = OW'(step_a);
    dn.next  = (cur_r.next != '0) ? OW'(AW'(cur_r.next) - step_a) : '0;
    pm_next  = (cur_r.next != '0) ? (mem_q.next + cur_r.next) : '0;
    pm       = mem_q;
    pm.size  = OW'(AW'(mem_q.size) + HDR_A + AW'(cur_r.size));
    pm.next  = pm_next;
  end

  // memory port selection
  always_comb begin
    ra = off_r;
    we = 1'b0;
    wa = off_r;
    wd = cur_r;
    case (cmd)
      ffa_pkg::CMD_ARD:  ra = off_r;
      ffa_pkg::CMD_FRD:  ra = foff[OW-1:0];
      ffa_pkg::CMD_FCHK: ra = a_sum[OW-1:0];
      ffa_pkg::CMD_FPV:  ra = poff;
      ffa_pkg::CMD_PRD:  ra = fol_sum[OW-1:0];
      ffa_pkg::CMD_SRD:  ra = soff_r;
      ffa_pkg::CMD_CLR: begin
        we = 1'b1;
        wa = clr_cnt_r;
        wd = '0;
        if (clr_cnt_r == '0) begin
          wd.start = 1'b1;
          wd.size  = INIT_SZ;
        end
      end
      ffa_pkg::CMD_AWC: begin
        we = 1'b1;
        wd = cur_r;
        wd.used = 1'b1;
        if (sts.split) begin
          wd.size = OW'(sz_a);
          wd.next = OW'(step_a);
        end
      end
      ffa_pkg::CMD_AWD: begin
        we = 1'b1;
        wa = OW'(AW'(off_r) + step_a);
        wd = dn;
      end
      ffa_pkg::CMD_PWR: begin
        we = 1'b1;
        wa = fol_sum[OW-1:0];
        wd = mem_q;
        wd.prev = prv_nx_r;
      end
      ffa_pkg::CMD_FNX: begin
        we = q_free;
        wa = noff;
        wd = '0;
      end
      ffa_pkg::CMD_FPC: begin
        we = q_free;
        wa = poff;
        wd = pm;
      end
      ffa_pkg::CMD_FZC: begin
        we = 1'b1;
        wd = '0;
      end
      ffa_pkg::CMD_FWC: begin
        we = 1'b1;
        wd = cur_r;
      end
      default: ;
    endcase
  end

  // header memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  // current chunk update
  always_comb begin
    cur_nxt = cur_r;
    case (cmd)
      ffa_pkg::CMD_ACHK: cur_nxt = mem_q;
      ffa_pkg::CMD_FCHK: begin
        cur_nxt = mem_q;
        cur_nxt.used = 1'b0;
      end
      ffa_pkg::CMD_FNX: begin
        if (q_free) begin
          cur_nxt.size = OW'(AW'(cur_r.size) + HDR_A + AW'(mem_q.size));
          cur_nxt.next = (mem_q.next != '0) ? (cur_r.next + mem_q.next) : '0;
        end
      end
      default: ;
    endcase
  end

  assign lf_sat = best_r;

  // walk and bookkeeping registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    case (cmd)
      ffa_pkg::CMD_LOAD: begin
        in_r     <= in_data;
        off_r    <= '0;
        soff_r   <= '0;
        best_r   <= '0;
        fail_r   <= 1'b0;
        merged_r <= 1'b0;
      end
      ffa_pkg::CMD_ACHK: begin
        if (!sts.fit && sts.a_end) begin
          fail_r <= 1'b1;
        end else if (!sts.fit) begin
          off_r <= a_sum[OW-1:0];
        end
      end
      ffa_pkg::CMD_AWD: begin
        prv_base_r <= OW'(AW'(off_r) + step_a);
        prv_nx_r   <= dn.next;
      end
      ffa_pkg::CMD_FRD: off_r <= foff[OW-1:0];
      ffa_pkg::CMD_FNX: begin
        if (q_free) begin
          merged_r <= 1'b1;
        end
      end
      ffa_pkg::CMD_FPC: begin
        if (q_free) begin
          merged_r   <= 1'b1;
          prv_base_r <= poff;
          prv_nx_r   <= pm_next;
        end
      end
      ffa_pkg::CMD_FWC: begin
        prv_base_r <= off_r;
        prv_nx_r   <= cur_r.next;
      end
      ffa_pkg::CMD_SCHK: begin
        if (q_free && (mem_q.size > best_r)) begin
          best_r <= mem_q.size;
        end
        soff_r <= s_sum[OW-1:0];
      end
      ffa_pkg::CMD_OUT: begin
        if (out_free) begin
          out_r.status <= fail_r;
          out_r.result_addr <= (fail_r || in_r.op == ffa_pkg::OP_FREE) ? '0 :
                               base + ffa_pkg::ADDR_W'(off_r) +
                               ffa_pkg::ADDR_W'(HEADER_BYTES);
          out_r.largest_free <= (AW'(lf_sat) > AW'(ffa_pkg::LF_MAX)) ? ffa_pkg::LF_MAX :
                                ffa_pkg::LF_W'(AW'(lf_sat));
        end
      end
      default: ;
    endcase
  end

  // clearing counter and output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == ffa_pkg::CMD_CLR) begin
        clr_cnt_r <= clr_cnt_r + OW'(1);
      end
      if (cmd == ffa_pkg::CMD_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* rtl/ffa_ctrl.sv */
// controller state machine of the heap allocator: sequences clear, search,
// split, merge and rescan; depends on ffa_pkg, drives ffa_dp
`default_nettype none

module ffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire ffa_pkg::sts_t sts,
  output logic               in_stall,
  output ffa_pkg::cmd_t      cmd
);

  typedef enum logic [17:0] {
    S_CLR  = 18'h00001,
    S_IDLE = 18'h00002,
    S_ARD  = 18'h00004,
    S_ACHK = 18'h00008,
    S_AWC  = 18'h00010,
    S_AWD  = 18'h00020,
    S_PRD  = 18'h00040,
    S_PWR  = 18'h00080,
    S_FRD  = 18'h00100,
    S_FCHK = 18'h00200,
    S_FNX  = 18'h00400,
    S_FPV  = 18'h00800,
    S_FPC  = 18'h01000,
    S_FZC  = 18'h02000,
    S_FWC  = 18'h04000,
    S_SRD  = 18'h08000,
    S_SCHK = 18'h10000,
    S_OUT  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd = ffa_pkg::CMD_NONE;
    case (state_r)
      S_CLR: begin
        cmd = ffa_pkg::CMD_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = ffa_pkg::CMD_LOAD;
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        cmd = sts.op_free ? ffa_pkg::CMD_FRD : ffa_pkg::CMD_ARD;
        if (sts.op_free) begin
          state_nxt = sts.foff_ok ? S_FCHK : S_SRD;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        cmd = ffa_pkg::CMD_ACHK;
        if (sts.fit) state_nxt = S_AWC;
        else if (sts.a_end) state_nxt = S_SRD;
        else state_nxt = S_ARD;
      end
      S_AWC: begin
        cmd = ffa_pkg::CMD_AWC;
        state_nxt = sts.split ? S_AWD : S_SRD;
      end
      S_AWD: begin
        cmd = ffa_pkg::CMD_AWD;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd = ffa_pkg::CMD_PRD;
        state_nxt = sts.fol_ok ? S_PWR : S_SRD;
      end
      S_PWR: begin
        cmd = ffa_pkg::CMD_PWR;
        state_nxt = S_SRD;
      end
      S_FRD: begin
        cmd = ffa_pkg::CMD_FRD;
        state_nxt = sts.foff_ok ? S_FCHK : S_SRD;
      end
      S_FCHK: begin
        cmd = ffa_pkg::CMD_FCHK;
        if (!sts.q_start) state_nxt = S_SRD;
        else if (sts.nx_ok) state_nxt = S_FNX;
        else state_nxt = S_FPV;
      end
      S_FNX: begin
        cmd = ffa_pkg::CMD_FNX;
        state_nxt = S_FPV;
      end
      S_FPV: begin
        cmd = ffa_pkg::CMD_FPV;
        state_nxt = sts.pv_ok ? S_FPC : S_FWC;
      end
      S_FPC: begin
        cmd = ffa_pkg::CMD_FPC;
        state_nxt = sts.q_free ? S_FZC : S_FWC;
      end
      S_FZC: begin
        cmd = ffa_pkg::CMD_FZC;
        state_nxt = S_PRD;
      end
      S_FWC: begin
        cmd = ffa_pkg::CMD_FWC;
        state_nxt = sts.merged ? S_PRD : S_SRD;
      end
      S_SRD: begin
        cmd = ffa_pkg::CMD_SRD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        cmd = ffa_pkg::CMD_SCHK;
        state_nxt = sts.s_end ? S_OUT : S_SRD;
      end
      S_OUT: begin
        cmd = ffa_pkg::CMD_OUT;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a beat is taken only from idle, then work starts
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ARD))
    else $error("accepted beat did not start work");

  // the rescan always precedes the result
  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> ($past(state_r) == S_SCHK || $past(state_r) == S_OUT))
    else $error("result without rescan");

  // clearing pass only leaves to idle
  a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && state_nxt != S_CLR) |-> sts.clr_last)
    else $error("clearing pass cut short");

endmodule

`default_nettype wire

/* tb/sv/first_fit_heap_allocator_tb.sv */
// self-checking bench for first_fit_heap_allocator: directed and random allocate/free beats
// depends on ffa_pkg and the first_fit_heap_allocator rtl
`default_nettype none

module first_fit_heap_allocator_tb;
  import ffa_pkg::*;

  localparam int HEAP = 4096;
  localparam int HDR  = 16;
  localparam int CLOSING_WAIT = 1200;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int TOTAL_ITEMS = 1170;
  localparam int QUIET_FROM = 1020;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow heap: header fields per byte offset
  bit hdr_start [HEAP];
  bit hdr_used [HEAP];
  int unsigned hdr_size [HEAP];
  int unsigned hdr_prev [HEAP];
  int unsigned hdr_next [HEAP];
  logic [31:0] shadow_base;

  in_t pending_beats[$];
  out_t expected_results[$];
  int unsigned granted_offs[$];
  int mismatches;
  int results_seen;
  int beats_popped;
  int allocs_sent;
  int frees_sent;
  int alloc_fails;
  longint cycles;
  bit quiet;
  int in_gap;
  int out_gap;

  localparam logic [31:0] HEAP_BASE_ADDR = 32'd0;

  function automatic void shadow_reset();
    for (int i = 0; i < HEAP; i++) begin
      hdr_start[i] = 0; hdr_used[i] = 0;
      hdr_size[i] = 0; hdr_prev[i] = 0; hdr_next[i] = 0;
    end
    hdr_start[0] = 1;
    hdr_size[0] = HEAP - HDR;
  endfunction

  function automatic void relink_follower(int unsigned off);
    int unsigned nx;
    nx = hdr_next[off];
    if (nx != 0 && off + nx < HEAP) hdr_prev[off + nx] = nx;
  endfunction

  function automatic void drop_header(int unsigned off);
    hdr_start[off] = 0; hdr_used[off] = 0;
    hdr_size[off] = 0; hdr_prev[off] = 0; hdr_next[off] = 0;
  endfunction

  // walk the chain for the largest free payload, saturating
  function automatic logic [LF_W-1:0] largest_free_scan();
    int unsigned off;
    int unsigned best;
    off = 0;
    best = 0;
    for (int n = 0; n < HEAP; n++) begin
      if (hdr_start[off] && !hdr_used[off] && hdr_size[off] > best) best = hdr_size[off];
      if (hdr_next[off] == 0 || off + hdr_next[off] >= HEAP) break;
      off += hdr_next[off];
    end
    return (best > LF_MAX) ? LF_MAX : best[LF_W-1:0];
  endfunction

  // first fit with split of the remainder
  function automatic out_t heap_allocate(logic [REQ_W-1:0] req);
    out_t r;
    int unsigned sz;
    int unsigned off;
    int unsigned stride;
    int unsigned noff;
    bit found;
    r = '0;
    sz = (int'(req) + 3) & ~3;
    off = 0;
    found = 0;
    for (int n = 0; n < HEAP; n++) begin
      if (hdr_start[off] && !hdr_used[off] && hdr_size[off] >= sz) begin
        found = 1;
        break;
      end
      if (hdr_next[off] == 0 || off + hdr_next[off] >= HEAP) break;
      off += hdr_next[off];
    end
    if (!found) begin
      r.status = ST_FAIL;
      return r;
    end
    stride = HDR + sz;
    if (hdr_size[off] > stride && off + stride < HEAP) begin
      noff = off + stride;
      hdr_start[noff] = 1;
      hdr_used[noff] = 0;
      hdr_size[noff] = hdr_size[off] - stride;
      hdr_prev[noff] = stride;
      hdr_next[noff] = (hdr_next[off] != 0) ? hdr_next[off] - stride : 0;
      relink_follower(noff);
      hdr_next[off] = stride;
      hdr_size[off] = sz;
    end
    hdr_used[off] = 1;
    granted_offs.push_back(off);
    r.result_addr = shadow_base + off + HDR;
    r.status = ST_OK;
    return r;
  endfunction

  // release with merge into free neighbors; bad addresses are ignored
  function automatic void heap_release(logic [31:0] a);
    logic [31:0] off32;
    int unsigned off;
    int unsigned noff;
    int unsigned poff;
    off32 = a - shadow_base - HDR;
    if (off32 >= HEAP) return;
    off = off32;
    if (!hdr_start[off]) return;
    hdr_used[off] = 0;
    if (hdr_next[off] != 0 && off + hdr_next[off] < HEAP) begin
      noff = off + hdr_next[off];
      if (hdr_start[noff] && !hdr_used[noff]) begin
        hdr_size[off] += HDR + hdr_size[noff];
        hdr_next[off] = (hdr_next[noff] != 0) ? hdr_next[off] + hdr_next[noff] : 0;
        drop_header(noff);
        relink_follower(off);
      end
    end
    if (hdr_prev[off] != 0 && hdr_prev[off] <= off) begin
      poff = off - hdr_prev[off];
      if (hdr_start[poff] && !hdr_used[poff]) begin
        hdr_size[poff] += HDR + hdr_size[off];
        hdr_next[poff] = (hdr_next[off] != 0) ? hdr_next[poff] + hdr_next[off] : 0;
        drop_header(off);
        relink_follower(poff);
      end
    end
  endfunction

  function automatic out_t heap_apply(in_t b);
    out_t r;
    if (b.op == OP_ALLOC) begin
      r = heap_allocate(b.req_size);
    end else begin
      heap_release(b.free_addr);
      r = '0;
      r.status = ST_OK;
    end
    r.largest_free = largest_free_scan();
    return r;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // input driver: pops pending beats, inserts random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        beats_popped++;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (in_data.op == OP_ALLOC) allocs_sent++;
      else frees_sent++;
      expected_results.push_back(heap_apply(in_data));
    end
  end

  // result stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 13);
    end
  end

  // result monitor: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (want.status == ST_FAIL) alloc_fails++;
        if (out_data.result_addr !== want.result_addr || out_data.status !== want.status
            || out_data.largest_free !== want.largest_free) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected addr %h st %0d lf %0d, got addr %h st %0d lf %0d",
                     results_seen, want.result_addr, want.status, want.largest_free,
                     out_data.result_addr, out_data.status, out_data.largest_free);
        end
      end
    end
  end

  task automatic write_heap_base(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= HEAP_BASE_ADDR[2:0]; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_base = v;
  endtask

  // every popped beat has come back as a result
  task automatic wait_drained();
    while (pending_beats.size() > 0 || results_seen < beats_popped)
      @(posedge clk);
  endtask

  function automatic in_t alloc_beat(int unsigned req);
    in_t b;
    b.op = OP_ALLOC;
    b.req_size = REQ_W'(req);
    b.free_addr = $urandom;
    return b;
  endfunction

  function automatic in_t free_beat(logic [31:0] a);
    in_t b;
    b.op = OP_FREE;
    b.req_size = REQ_W'($urandom_range(0, 4096));
    b.free_addr = a;
    return b;
  endfunction

  function automatic in_t random_beat();
    int r;
    int sel;
    int unsigned off;
    r = $urandom_range(0, 99);
    if (r < 45 && granted_offs.size() > 0) begin
      sel = $urandom_range(0, granted_offs.size() - 1);
      off = granted_offs[sel];
      granted_offs.delete(sel);
      return free_beat(shadow_base + off + HDR);
    end
    if (r < 50) return free_beat($urandom);
    if (r < 53) return free_beat(shadow_base + $urandom_range(0, 4200));
    r = $urandom_range(0, 99);
    if (r < 80) return alloc_beat($urandom_range(0, 120));
    if (r < 95) return alloc_beat($urandom_range(0, 1024));
    return alloc_beat($urandom_range(0, 4096));
  endfunction

  // stimulus: directed beats, then random phases under several heap bases
  initial begin
    logic [31:0] bases [4];
    int made;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    mismatches = 0; results_seen = 0; beats_popped = 0; allocs_sent = 0; frees_sent = 0;
    alloc_fails = 0; cycles = 0; quiet = 0; in_gap = 0; out_gap = 0;
    shadow_base = '0;
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_heap_base(32'h0);

    // edge sizes, split and no-split grants, merges and bad frees
    pending_beats.push_back(alloc_beat(0));
    pending_beats.push_back(alloc_beat(1));
    pending_beats.push_back(alloc_beat(5));
    pending_beats.push_back(free_beat(32'd16));
    pending_beats.push_back(free_beat(32'd3));
    pending_beats.push_back(free_beat(32'd16));
    pending_beats.push_back(free_beat(32'd32));
    pending_beats.push_back(free_beat(32'd52));
    pending_beats.push_back(alloc_beat(4096));
    pending_beats.push_back(alloc_beat(4080));
    pending_beats.push_back(alloc_beat(1));
    pending_beats.push_back(free_beat(32'd16));
    pending_beats.push_back(alloc_beat(4064));
    pending_beats.push_back(free_beat(32'd16));
    pending_beats.push_back(alloc_beat(4060));
    pending_beats.push_back(free_beat(32'hFFFF_FFFF));
    pending_beats.push_back(free_beat(32'd16));
    made = pending_beats.size();
    wait_drained();
    granted_offs.delete();

    bases[0] = 32'hFFFF_FFFC;
    bases[1] = $urandom_range(0, 32'h3FFF_FFFF) << 2;
    bases[2] = 32'h0000_1000;
    bases[3] = 32'h0;
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      repeat (20) @(posedge clk);
      write_heap_base(bases[p]);
      while (made < 17 + (p + 1) * (TOTAL_ITEMS - 17) / 4) begin
        if (made >= QUIET_FROM) quiet = 1;
        for (int k = 0; k < 16; k++) pending_beats.push_back(random_beat());
        made += 16;
        wait_drained();
      end
    end

    wait_drained();
    repeat (CLOSING_WAIT) @(posedge clk);
    if (expected_results.size() > 0) mismatches++;
    $display("ran %0d allocates (%0d refused) and %0d frees over four heap bases",
             allocs_sent, alloc_fails, frees_sent);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/ffa_pkg.sv
rtl/ffa_dp.sv
rtl/ffa_ctrl.sv
rtl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
